FILE: design/axis_move_duty_controller_top_defines.svh
// Assertion macros for the move duty controller.
`ifndef AXIS_MOVE_DUTY_CONTROLLER_TOP_DEFINES_SVH
`define AXIS_MOVE_DUTY_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AMDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AMDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/amdc_pkg.sv
// Types, constants and helpers shared by the move duty controller.
package amdc_pkg;

  localparam int DUTY_SCALE = 200;
  localparam int DUTY_MAX   = 70;
  localparam int DUTY_MIN   = 30;

  // Divider widths: 200 * 65535 fits in 24 bits.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic MODE_MOVE  = 1'b0;
  localparam logic MODE_PULSE = 1'b1;

  // One axis entry as stored in the state memory.
  typedef struct packed {
    logic signed [15:0] cnt;
    logic signed [15:0] pos;
    logic signed [15:0] len;
    logic               run;
    logic               dir;
  } amdc_entry_t;

  // Start/finish handshake with the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } amdc_div_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? (16'd0 - v) : v;
    return r;
  endfunction

  function automatic logic [15:0] mag17(input logic signed [16:0] v);
    logic [16:0] r;
    r = v[16] ? (17'd0 - v) : v;
    return r[15:0];
  endfunction

endpackage

FILE: design/axis_move_duty_controller_top.sv
// Top level of the three-axis move duty controller.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_valid/in_ready  | in_mode, in_axis, in_target
//  out_    | out | out_valid/out_ready| out_axis_out, out_duty, out_direction,
//          |     |                    | out_running, out_position
//
// One item at a time. A transfer that leaves the axis running goes through
// the 24-step serial divider for the duty ratio; a stopped axis skips the
// divider, and an out-of-range axis skips the duty step as well.
// Reset (rst_n low, synchronous) clears the per-axis valid bits, so every axis
// reads as zero/stopped at once; no clearing pass.
// The result sits in an output register: a new item is taken while it waits,
// and the block only stalls in its final state if that register is still full.

module axis_move_duty_controller_top #(
  parameter int NUM_AXES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [1:0]          in_axis,
  input  logic signed [15:0]  in_target,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_axis_out,
  output logic [6:0]          out_duty,
  output logic                out_direction,
  output logic                out_running,
  output logic signed [15:0]  out_position
);
  import amdc_pkg::*;

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // ready for a transfer, memory read issued
  localparam logic [2:0] S_UPD  = 3'd1;  // read data back: modify and write back
  localparam logic [2:0] S_PREP = 3'd2;  // pick duty numerator, scale by 200
  localparam logic [2:0] S_DIV  = 3'd3;  // wait on the divider
  localparam logic [2:0] S_DONE = 3'd4;  // hand result to the output register

  logic [2:0]           state_r, state_nxt;

  // Accepted item
  logic                 in_xfer;
  logic [AW+1:0]        axis_ext;
  logic [AW-1:0]        idx_in;
  logic                 in_rng;
  logic                 mode_r;
  logic [1:0]           axis_r;
  logic [AW-1:0]        idx_r;
  logic                 rng_r;
  logic signed [15:0]   target_r;

  // State memory: one entry per axis, valid bits stand in for reset
  amdc_entry_t          mem [NUM_AXES];
  logic [NUM_AXES-1:0]  vld_r;
  amdc_entry_t          rd_data_r;
  logic                 rd_vld_r;
  amdc_entry_t          ent;
  amdc_entry_t          ent_n;
  logic                 mem_we;

  // Updated axis fields
  amdc_entry_t          upd_r;

  // Read-modify-write scratch
  logic signed [16:0]   pos_sum;
  logic signed [15:0]   pos_n;
  logic signed [16:0]   len_diff;
  logic signed [15:0]   len_n;
  logic signed [16:0]   cnt_step;
  logic signed [15:0]   cnt_n;
  logic signed [16:0]   rem_err;

  // Duty numerator
  logic signed [16:0]   err17;
  logic [15:0]          cmag, emag, lmag, sel_mag;
  logic                 duty_live;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic                 div_go_r;
  logic [DIV_NUM_W-1:0] div_quo;
  amdc_div_stat_t       div_stat;
  logic [6:0]           duty_r;
  logic [6:0]           duty_clamp;

  // Output register
  logic                 out_valid_r;
  logic [1:0]           out_axis_r;
  logic [6:0]           out_duty_r;
  logic                 out_dir_r;
  logic                 out_run_r;
  logic signed [15:0]   out_pos_r;
  logic                 out_load;
  logic                 duty_band;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign axis_ext = {{AW{1'b0}}, in_axis};
  assign idx_in   = axis_ext[AW-1:0];
  assign in_rng   = (32'(in_axis) < 32'(NUM_AXES));

  // ---------------------------------------------------------------------------
  // Modify: fold count into position on a move, count one step on a pulse.
  // ---------------------------------------------------------------------------
  assign ent = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    pos_sum  = {ent.pos[15], ent.pos} + {ent.cnt[15], ent.cnt};
    pos_n    = sat16(pos_sum);
    len_diff = {target_r[15], target_r} - {pos_n[15], pos_n};
    len_n    = sat16(len_diff);
    cnt_step = {ent.cnt[15], ent.cnt} + (ent.dir ? 17'sd1 : -17'sd1);
    cnt_n    = sat16(cnt_step);
    rem_err  = {ent.len[15], ent.len} - {cnt_n[15], cnt_n};
    ent_n    = ent;
    unique case (mode_r)
      MODE_MOVE: begin
        ent_n.pos = pos_n;
        ent_n.cnt = '0;
        ent_n.len = len_n;
        ent_n.run = (len_n != 16'sd0);
        ent_n.dir = !len_n[15];
      end
      MODE_PULSE: begin
        // a stopped axis has its counter paused
        if (ent.run) begin
          ent_n.cnt = cnt_n;
          if (cnt_n == ent.len) begin
            ent_n.run = 1'b0;
          end else begin
            ent_n.dir = !rem_err[16];
          end
        end
      end
      default: ent_n = ent;
    endcase
  end

  assign mem_we = (state_r == S_UPD) && rng_r;

  // ---------------------------------------------------------------------------
  // Duty: 200*|count| in the first half, 200*|length - count| in the second.
  // ---------------------------------------------------------------------------
  always_comb begin
    err17     = {upd_r.len[15], upd_r.len} - {upd_r.cnt[15], upd_r.cnt};
    cmag      = mag16(upd_r.cnt);
    emag      = mag17(err17);
    lmag      = mag16(upd_r.len);
    sel_mag   = (cmag < (lmag >> 1)) ? cmag : emag;
    duty_live = upd_r.run && (upd_r.len != 16'sd0);
  end

  always_comb begin
    priority if (div_quo > DIV_NUM_W'(DUTY_MAX)) begin
      duty_clamp = 7'(DUTY_MAX);
    end else if (div_quo < DIV_NUM_W'(DUTY_MIN)) begin
      duty_clamp = 7'(DUTY_MIN);
    end else begin
      duty_clamp = div_quo[6:0];
    end
  end

  amdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num_r),
    .den   (den_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_UPD;
      S_UPD:  state_nxt = rng_r ? S_PREP : S_DONE;
      S_PREP: state_nxt = duty_live ? S_DIV : S_DONE;
      S_DIV:  if (div_stat.done) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vld_r    <= '0;
      div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (state_r == S_PREP) && duty_live;
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Memory: synchronous read issued on the transfer, write back in S_UPD.
  // The sequencer keeps the next read behind the write, so no forwarding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= ent_n;
    end
    if (in_xfer && in_rng) begin
      rd_data_r <= mem[idx_in];
      rd_vld_r  <= vld_r[idx_in];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r   <= in_mode;
      axis_r   <= in_axis;
      idx_r    <= idx_in;
      rng_r    <= in_rng;
      target_r <= in_target;
    end
    if (state_r == S_UPD) begin
      // out-of-range axis reports zero state and duty
      upd_r  <= rng_r ? ent_n : '0;
      duty_r <= '0;
    end
    if (state_r == S_PREP) begin
      num_r  <= DIV_NUM_W'(sel_mag) * DIV_NUM_W'(DUTY_SCALE);
      den_r  <= lmag;
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      duty_r <= duty_clamp;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_axis_r <= axis_r;
      out_duty_r <= duty_r;
      out_dir_r  <= upd_r.dir;
      out_run_r  <= upd_r.run;
      out_pos_r  <= upd_r.pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_axis_out  = out_axis_r;
  assign out_duty      = out_duty_r;
  assign out_direction = out_dir_r;
  assign out_running   = out_run_r;
  assign out_position  = out_pos_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `include "axis_move_duty_controller_top_defines.svh"

  assign duty_band = (out_duty >= 7'(DUTY_MIN)) && (out_duty <= 7'(DUTY_MAX));

  `AMDC_ASSERT_IMP(a_stop_duty, out_valid && !out_running, out_duty == 7'd0, "stopped with duty")
  `AMDC_ASSERT_IMP(a_run_duty, out_valid && out_running, duty_band, "running duty out of range")
  `AMDC_ASSERT_IMP(a_div_den, div_go_r, den_r != '0, "divider started with zero divisor")
  `AMDC_ASSERT_NXT(a_div_busy, div_go_r, div_stat.busy && (state_r == S_DIV), "divider idle")

endmodule

FILE: design/amdc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module amdc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [amdc_pkg::DIV_NUM_W-1:0]     num,
  input  logic [amdc_pkg::DIV_DEN_W-1:0]     den,
  output logic [amdc_pkg::DIV_NUM_W-1:0]     quo,
  output amdc_pkg::amdc_div_stat_t           stat
);
  import amdc_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_NUM_W-1:0]  quo_r;
  logic [DIV_DEN_W-1:0]  rem_r;
  logic [DIV_DEN_W-1:0]  den_r;
  logic [DIV_DEN_W:0]    rem_sh;
  logic [DIV_DEN_W:0]    rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
